// ===== sv/fhs_pkg.sv =====
// Shared types, register indexes and constants of the frequency shifter.
package fhs_pkg;

  // Configuration register indexes
  localparam logic [3:0] REG_COEF_0   = 4'd0;
  localparam logic [3:0] REG_COEF_1   = 4'd1;
  localparam logic [3:0] REG_COEF_2   = 4'd2;
  localparam logic [3:0] REG_COEF_3   = 4'd3;
  localparam logic [3:0] REG_STEP     = 4'd4;
  localparam logic [3:0] REG_OFFSET   = 4'd5;
  localparam logic [3:0] REG_LEVEL    = 4'd6;
  localparam logic [3:0] REG_CHANNELS = 4'd7;

  localparam int          REG_COEFS   = 16;
  localparam logic [16:0] LEVEL_UNITY = 17'd65536;

  // Odd sine polynomial, Q30
  localparam logic signed [33:0] SA1 = 34'sd1686629713;
  localparam logic signed [33:0] SA3 = -34'sd693598668;
  localparam logic signed [33:0] SA5 = 34'sd85569306;
  localparam logic signed [33:0] SA7 = -34'sd5026995;
  localparam logic signed [33:0] SA9 = 34'sd172272;

  typedef logic [3:0][63:0] coef_words_t;

  // One accepted item as it waits for the back end
  typedef struct packed {
    logic signed [23:0] sample;
    logic [2:0]         ch;
    logic [31:0]        phase;
    logic               nostate;
  } item_t;

  // Horner coefficient for step h (after the SA9 seed)
  function automatic logic signed [33:0] horner_coef(input logic [1:0] h);
    logic signed [33:0] c;
    unique case (h)
      2'd0: c = SA7;
      2'd1: c = SA5;
      2'd2: c = SA3;
      default: c = SA1;
    endcase
    return c;
  endfunction

  // Coefficient of section j; sections past the register set use zero
  function automatic logic [15:0] coef_of(input coef_words_t w, input int j);
    logic [15:0] c;
    c = '0;
    if (j < REG_COEFS) begin
      c = w[(j >> 2) & 3][16*(j & 3) +: 16];
    end
    return c;
  endfunction

endpackage

// ===== sv/fhs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fhs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/fhs_front.sv =====
// Front end: accepts beats, stamps each with its phase and advances the accumulator.
module fhs_front
  import fhs_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [23:0] in_sample,
  input  logic [2:0]         in_ch,
  input  logic [31:0]        phase_step,
  input  logic [31:0]        phase_offset,
  input  logic [3:0]         channel_count,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  localparam int CMAX = (CHANNELS < 8) ? CHANNELS : 8;

  logic [31:0] accum_r, accum_nxt;
  logic [3:0]  cnt;
  logic        last_ch;

  assign in_tready = !clearing && !q_full;
  assign q_push    = in_tvalid && in_tready;

  // Clamp the channel count to its legal range
  always_comb begin
    cnt = channel_count;
    if (cnt == 4'd0) begin
      cnt = 4'd1;
    end
    if (cnt > 4'(CMAX)) begin
      cnt = 4'(CMAX);
    end
  end

  assign last_ch = ({1'b0, in_ch} == (cnt - 4'd1));

  always_comb begin
    q_item.sample  = in_sample;
    q_item.ch      = in_ch;
    q_item.phase   = accum_r + phase_offset;
    q_item.nostate = (int'(in_ch) >= CHANNELS);
  end

  // Advance the accumulator after the last channel of a time step
  always_comb begin
    accum_nxt = accum_r;
    if (q_push && last_ch) begin
      accum_nxt = accum_r + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

endmodule

// ===== sv/fhs_fifo.sv =====
// Two-entry queue between the front and back ends.
module fhs_fifo
  import fhs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t       slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/fhs_back.sv =====
// Back end: allpass sections over the state RAM, sine/cosine and rotation on one multiplier.
module fhs_back
  import fhs_pkg::*;
#(
  parameter int CHANNELS   = 8,
  parameter int SECTIONS   = 16,
  parameter int STATE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  input  coef_words_t        coef_words,
  input  logic [16:0]        output_level,
  output logic               clearing,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic signed [23:0] out_sample,
  output logic [2:0]         out_ch
);

  localparam int SB    = STATE_BITS;
  localparam int FRAC  = SB - 8;
  localparam int DEPTH = CHANNELS * SECTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int JW    = $clog2(SECTIONS);
  localparam int RW    = 4 * SB;
  localparam int MA    = (SB > 34) ? SB : 34;
  localparam int MP    = MA + 34;
  localparam int TW    = SB + 8;
  localparam int XL    = (FRAC >= 23) ? FRAC - 23 : 0;
  localparam int XR    = (FRAC >= 23) ? 0 : 23 - FRAC;
  localparam int QL    = (FRAC >= 24) ? 0 : 24 - FRAC;
  localparam int QR    = (FRAC >= 24) ? FRAC - 24 : 0;

  localparam logic [JW-1:0] J_LAST   = JW'(SECTIONS - 1);
  localparam logic [JW-1:0] J_I_LAST = JW'(SECTIONS / 2 - 1);

  localparam logic signed [TW-1:0] Q_HI   = TW'(64'sh7fffffff);
  localparam logic signed [TW-1:0] Q_LO   = TW'(-64'sh80000000);
  localparam logic signed [MP-1:0] OUT_HI = MP'(24'sh7fffff);
  localparam logic signed [MP-1:0] OUT_LO = MP'(24'sh800000);

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_RD    = 12'b0000_0000_0100,
    ST_MUL   = 12'b0000_0000_1000,
    ST_WR    = 12'b0000_0001_0000,
    ST_TZ    = 12'b0000_0010_0000,
    ST_TH    = 12'b0000_0100_0000,
    ST_TU    = 12'b0000_1000_0000,
    ST_TI    = 12'b0001_0000_0000,
    ST_TQ    = 12'b0010_0000_0000,
    ST_TL    = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

  // Saturate a widened state value back to SB bits
  function automatic logic signed [SB-1:0] sat_state(input logic signed [SB+1:0] v);
    logic ok;
    ok = (&v[SB+1:SB-1]) | ~(|v[SB+1:SB-1]);
    return ok ? v[SB-1:0] : {v[SB+1], {(SB-1){~v[SB+1]}}};
  endfunction

  // Bring a state value to Q8.24, saturated to 32 bits
  function automatic logic signed [33:0] to_q24(input logic signed [SB-1:0] v);
    logic signed [TW-1:0] t;
    logic signed [31:0]   r;
    t = (TW'(v) <<< QL) >>> QR;
    if (t > Q_HI) begin
      r = 32'sh7fffffff;
    end else if (t < Q_LO) begin
      r = 32'sh80000000;
    end else begin
      r = t[31:0];
    end
    return 34'(r);
  endfunction

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, addr_r;
  logic [JW-1:0]       j_r;
  logic [1:0]          h_r;
  logic                sel_r;
  logic signed [SB-1:0] x_r, xs_r, i_r, q_r;
  logic [2:0]          ch_r;
  logic [31:0]         ph_r;
  logic signed [MP-1:0] prod_r;
  logic signed [33:0]  z_r, p_r, cos_r, sin_r, acc_r;
  logic signed [63:0]  p1_r;
  logic signed [23:0]  res_r;
  logic                out_tvalid_r;
  logic signed [23:0]  out_sample_r;
  logic [2:0]          out_ch_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata, ram_rdata;
  logic signed [SB-1:0] in_d1, in_d2, out_d1, out_d2, sum_sat, y_val, xs_new;
  logic signed [SB+1:0] sum_w, y_w;
  logic [31:0]         ph_s;
  logic [30:0]         u31;
  logic signed [33:0]  u34, s_val, lvl;
  logic signed [MA-1:0] ma;
  logic signed [33:0]  mb;
  logic signed [MP-1:0] prod, prod_sh;
  logic signed [63:0]  diff;
  logic                out_free;

  fhs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  assign out_d2 = ram_rdata[SB-1:0];
  assign out_d1 = ram_rdata[2*SB-1:SB];
  assign in_d2  = ram_rdata[3*SB-1:2*SB];
  assign in_d1  = ram_rdata[4*SB-1:3*SB];

  assign clearing   = (state_r == ST_CLEAR);
  assign out_free   = !out_tvalid_r || out_tready;
  assign q_pop      = (state_r == ST_IDLE) && !q_empty;
  assign out_tvalid = out_tvalid_r;
  assign out_sample = out_sample_r;
  assign out_ch     = out_ch_r;

  // Input scaled into state format
  assign xs_new = (SB'(q_item.sample) <<< XL) >>> XR;

  // Section datapath
  assign sum_w   = (SB+2)'(x_r) + (SB+2)'(out_d2);
  assign sum_sat = sat_state(sum_w);
  assign y_w     = (SB+2)'(prod_r >>> 16) - (SB+2)'(in_d2);
  assign y_val   = sat_state(y_w);

  // Sine argument and quadrant fold
  assign ph_s  = sel_r ? ph_r : ph_r + 32'h4000_0000;
  assign u31   = ph_s[30] ? (31'h4000_0000 - {1'b0, ph_s[29:0]}) : {1'b0, ph_s[29:0]};
  assign u34   = $signed({3'b000, u31});
  assign lvl   = $signed({17'd0, (output_level > LEVEL_UNITY) ? LEVEL_UNITY : output_level});

  // Select operands for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_MUL: begin
        ma = MA'(sum_sat);
        mb = $signed({18'd0, coef_of(coef_words, int'(j_r))});
      end
      ST_TZ: begin
        ma = MA'(u34);
        mb = u34;
      end
      ST_TH: begin
        ma = MA'(p_r);
        mb = z_r;
      end
      ST_TU: begin
        ma = MA'(p_r);
        mb = u34;
      end
      ST_TI: begin
        ma = MA'(to_q24(i_r));
        mb = cos_r;
      end
      ST_TQ: begin
        ma = MA'(to_q24(q_r));
        mb = sin_r;
      end
      ST_TL: begin
        ma = MA'(acc_r);
        mb = lvl;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = MP'(ma) * MP'(mb);
  assign prod_sh = prod >>> 30;
  assign s_val   = ph_s[31] ? -34'(prod_sh) : 34'(prod_sh);
  assign diff    = p1_r - 64'(prod);

  // State RAM write: zero sweep after reset, else section update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {x_r, in_d1, y_val, out_d1};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_WR) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_item.nostate ? ST_OUT : ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WR;
      ST_WR:  state_nxt = (j_r == J_LAST) ? ST_TZ : ST_RD;
      ST_TZ:  state_nxt = ST_TH;
      ST_TH:  if (h_r == 2'd3) state_nxt = ST_TU;
      ST_TU:  state_nxt = sel_r ? ST_TI : ST_TZ;
      ST_TI:  state_nxt = ST_TQ;
      ST_TQ:  state_nxt = ST_TL;
      ST_TL:  state_nxt = ST_OUT;
      ST_OUT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      // Hand the result to the output register; drop valid when taken
      if (state_r == ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        ch_r   <= q_item.ch;
        ph_r   <= q_item.phase;
        xs_r   <= xs_new;
        x_r    <= xs_new;
        j_r    <= '0;
        sel_r  <= 1'b0;
        res_r  <= '0;
        addr_r <= AW'(int'(q_item.ch) * SECTIONS);
      end
      ST_MUL: begin
        prod_r <= prod;
        if (j_r == J_LAST) begin
          q_r <= out_d1;
        end
      end
      ST_WR: begin
        x_r    <= (j_r == J_I_LAST) ? xs_r : y_val;
        if (j_r == J_I_LAST) begin
          i_r <= y_val;
        end
        j_r    <= j_r + JW'(1);
        addr_r <= addr_r + AW'(1);
      end
      ST_TZ: begin
        z_r <= 34'(prod_sh);
        p_r <= SA9;
        h_r <= 2'd0;
      end
      ST_TH: begin
        p_r <= horner_coef(h_r) + 34'(prod_sh);
        h_r <= h_r + 2'd1;
      end
      ST_TU: begin
        if (sel_r) begin
          sin_r <= s_val;
        end else begin
          cos_r <= s_val;
        end
        sel_r <= ~sel_r;
      end
      ST_TI: p1_r  <= 64'(prod);
      ST_TQ: acc_r <= 34'(diff >>> 30);
      ST_TL: begin
        if ((prod >>> 17) > OUT_HI) begin
          res_r <= 24'sh7fffff;
        end else if ((prod >>> 17) < OUT_LO) begin
          res_r <= 24'sh800000;
        end else begin
          res_r <= 24'(prod >>> 17);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_sample_r <= res_r;
          out_ch_r     <= ch_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/iir_hilbert_frequency_shifter.sv =====
// Top level of the IIR Hilbert frequency shifter: register file, front end, queue, back end.
// Each sample beat of a channel below CHANNELS runs through SECTIONS allpass sections, each
// a state RAM read, a multiply and a write back, then two sine evaluations and the rotation on
// one shared multiplier; a two-entry queue lets the front keep taking beats meanwhile and the
// output register holds a finished beat while the next one is processed. After reset the state
// RAM is swept to zero over all CHANNELS*SECTIONS entries (128 at the defaults) before the first
// beat is accepted; configuration writes are taken at any time and are meant to be made while
// the block is idle.
module iir_hilbert_frequency_shifter
  import fhs_pkg::*;
#(
  parameter int CHANNELS   = 8,
  parameter int SECTIONS   = 16,
  parameter int STATE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  input  logic [2:0]  in_tuser,   // [2:0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] sample_out
  output logic [2:0]  out_tuser,  // [2:0] out_channel
  input  logic        cfg_we,
  input  logic [3:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  coef_words_t        coef_r;
  logic [31:0]        step_r, offset_r;
  logic [16:0]        level_r;
  logic [3:0]         count_r;
  logic               clearing, q_full, q_empty, q_push, q_pop;
  item_t              push_item, pop_item;
  logic signed [23:0] out_sample;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      step_r   <= '0;
      offset_r <= '0;
      level_r  <= LEVEL_UNITY;
      count_r  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEF_0:   coef_r[0] <= cfg_wdata;
        REG_COEF_1:   coef_r[1] <= cfg_wdata;
        REG_COEF_2:   coef_r[2] <= cfg_wdata;
        REG_COEF_3:   coef_r[3] <= cfg_wdata;
        REG_STEP:     step_r    <= cfg_wdata[31:0];
        REG_OFFSET:   offset_r  <= cfg_wdata[31:0];
        REG_LEVEL:    level_r   <= cfg_wdata[16:0];
        REG_CHANNELS: count_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  fhs_front #(.CHANNELS(CHANNELS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_sample     ($signed(in_tdata)),
    .in_ch         (in_tuser),
    .phase_step    (step_r),
    .phase_offset  (offset_r),
    .channel_count (count_r),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  fhs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  fhs_back #(
    .CHANNELS   (CHANNELS),
    .SECTIONS   (SECTIONS),
    .STATE_BITS (STATE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .coef_words   (coef_r),
    .output_level (level_r),
    .clearing     (clearing),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_sample   (out_sample),
    .out_ch       (out_tuser)
  );

  assign out_tdata = out_sample;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the frequency shifter: stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
  import fhs_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 100;
  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = -24'sh800000;

  typedef struct packed {
    logic [23:0] smp;
    logic [2:0]  ch;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [23:0] sample_in
  logic [2:0]  in_tuser = '0;   // [2:0] channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [23:0] sample_out
  logic [2:0]  out_tuser;       // [2:0] out_channel
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  iir_hilbert_frequency_shifter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow registers and filter state
  logic [63:0] coef_w [4];
  logic [31:0] step_r, offset_r, accum;
  logic [16:0] level_r;
  logic [3:0]  count_r;
  longint      in_d1 [128], in_d2 [128], out_d1 [128], out_d2 [128];

  beat_t  pending_beats [$];
  beat_t  shifted_q [$];
  int     n_queued = 0, n_taken = 0, errors = 0, cycles = 0;
  bit     taken = 0, calm = 0;
  int     in_gap = 0, out_gap = 0;

  function automatic longint clip(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint sine_q30(input logic [31:0] ph);
    longint u, z, p, s;
    u = longint'(ph[29:0]);
    if (ph[30]) u = (longint'(1) <<< 30) - u;
    z = (u * u) >>> 30;
    p = longint'(SA9);
    p = longint'(SA7) + ((p * z) >>> 30);
    p = longint'(SA5) + ((p * z) >>> 30);
    p = longint'(SA3) + ((p * z) >>> 30);
    p = longint'(SA1) + ((p * z) >>> 30);
    s = (p * u) >>> 30;
    return ph[31] ? -s : s;
  endfunction

  // Run one sample through both allpass chains and the rotator, queue the result
  function automatic void shift_sample(input logic [23:0] din, input logic [2:0] ch);
    longint xs, x, sum, y, ival, qval, acc, lvl, c;
    int     base, k, cnt;
    logic [31:0] ph;
    beat_t  b;
    ph = accum + offset_r;
    cnt = (count_r == 0) ? 1 : ((count_r > 8) ? 8 : int'(count_r));
    base = int'(ch) * 16;
    xs = longint'($signed(din)) * 2;
    x = xs;
    ival = 0;
    for (int j = 0; j < 16; j++) begin
      k = base + j;
      if (j == 8) x = xs;
      c = longint'(coef_w[j >> 2][16 * (j & 3) +: 16]);
      sum = clip(x + out_d2[k], 32);
      y = clip(((sum * c) >>> 16) - in_d2[k], 32);
      in_d2[k] = in_d1[k];
      in_d1[k] = x;
      out_d2[k] = out_d1[k];
      out_d1[k] = y;
      x = y;
      if (j == 7) ival = y;
    end
    qval = out_d2[base + 15];
    acc = clip(ival, 32) * sine_q30(ph + 32'h4000_0000) - clip(qval, 32) * sine_q30(ph);
    acc = acc >>> 30;
    lvl = (level_r > LEVEL_UNITY) ? longint'(LEVEL_UNITY) : longint'(level_r);
    b.smp = 24'(clip((acc * lvl) >>> 17, 24));
    b.ch = ch;
    shifted_q.push_back(b);
    if (int'(ch) == cnt - 1) accum = accum + step_r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Take accepted beats into the predictor, compare result beats, count cycles
  always @(posedge clk) begin
    beat_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      if (rst_n && in_tvalid && in_tready) begin
        shift_sample(in_tdata, in_tuser);
        n_taken = n_taken + 1;
        taken = 1;
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (shifted_q.size() == 0) begin
          $error("unexpected result beat: sample_out %0d channel %0d",
                 $signed(out_tdata), out_tuser);
          errors++;
        end else begin
          e = shifted_q.pop_front();
          if (out_tdata !== e.smp) begin
            $error("sample_out: expected %0d, actual %0d", $signed(e.smp), $signed(out_tdata));
            errors++;
          end
          if (out_tuser !== e.ch) begin
            $error("out_channel: expected %0d, actual %0d", e.ch, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Drive input beats from the pending queue, with random gaps
  always @(negedge clk) begin
    beat_t b;
    logic  v;
    v = in_tvalid;
    if (rst_n && (taken || !in_tvalid)) begin
      v = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        in_tdata <= b.smp;
        in_tuser <= b.ch;
        v = 1'b1;
        in_gap = pick_gap();
      end
    end
    taken = 0;
    in_tvalid <= v;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3: coef_w[idx[1:0]] = val;
      REG_STEP:     step_r = val[31:0];
      REG_OFFSET:   offset_r = val[31:0];
      REG_LEVEL:    level_r = val[16:0];
      REG_CHANNELS: count_r = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input logic [23:0] s, input logic [2:0] ch);
    beat_t b;
    b.smp = s;
    b.ch = ch;
    pending_beats.push_back(b);
    n_queued++;
  endtask

  // Wait for every queued beat to come back, then let the pipeline settle
  task automatic drain();
    while (n_taken != n_queued || shifted_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    int r;
    r = $urandom_range(19);
    if (r == 0) return SMP_MAX;
    if (r == 1) return SMP_MIN;
    if (r < 8) return 24'($signed($urandom_range(20000)) - 10000);
    return 24'($urandom);
  endfunction

  task automatic random_phase(input int items);
    int ch, cnt;
    cnt = (count_r == 0) ? 1 : ((count_r > 8) ? 8 : int'(count_r));
    ch = 0;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(9) < 8) begin
        send(rand_sample(), 3'(ch));
        ch = (ch + 1) % cnt;
      end else begin
        send(rand_sample(), 3'($urandom_range(7)));
      end
    end
    drain();
  endtask

  initial begin
    logic [63:0] w;
    for (int k = 0; k < 128; k++) begin
      in_d1[k] = 0; in_d2[k] = 0; out_d1[k] = 0; out_d2[k] = 0;
    end
    for (int k = 0; k < 4; k++) coef_w[k] = '0;
    step_r = '0; offset_r = '0; accum = '0; level_r = LEVEL_UNITY; count_r = 4'd1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, then field extremes on every channel
    send(SMP_MAX, 3'd0);
    send(SMP_MIN, 3'd0);
    drain();
    for (int k = 0; k < 4; k++) write_reg(REG_COEF_0 + 4'(k), {$urandom, $urandom});
    write_reg(REG_CHANNELS, 64'd8);
    write_reg(REG_STEP, 64'h0000_0000_1000_0000);
    send(SMP_MAX, 3'd0); send(SMP_MIN, 3'd1); send(24'd0, 3'd2); send(24'hFFFFFF, 3'd3);
    send(24'd1, 3'd4); send(SMP_MAX, 3'd5); send(SMP_MIN, 3'd6); send(SMP_MAX, 3'd7);
    drain();

    // Directed: level above unity, zero channel count, unknown register
    write_reg(REG_LEVEL, 64'd131071);
    write_reg(REG_CHANNELS, 64'd0);
    write_reg(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(4'd15, 64'h1234);
    write_reg(REG_OFFSET, 64'hFFFF_FFFF);
    send(SMP_MAX, 3'd0); send(SMP_MIN, 3'd0); send(SMP_MAX, 3'd5);
    drain();

    // Directed: count beyond range, channels past the count, coefficients near one
    write_reg(REG_CHANNELS, 64'd15);
    write_reg(REG_LEVEL, 64'd65537);
    for (int k = 0; k < 4; k++) write_reg(REG_COEF_0 + 4'(k), 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_STEP, 64'h8000_0000);
    send(SMP_MAX, 3'd7); send(SMP_MAX, 3'd7); send(SMP_MIN, 3'd3);
    drain();
    write_reg(REG_CHANNELS, 64'd2);
    send(SMP_MIN, 3'd6); send(SMP_MAX, 3'd1);
    drain();

    // Random phases over a spread of settings
    for (int p = 0; p < 7; p++) begin
      calm = ($urandom_range(3) == 0);
      for (int k = 0; k < 4; k++) begin
        w = {$urandom, $urandom};
        if (p == 1) w = '0;
        write_reg(REG_COEF_0 + 4'(k), w);
      end
      write_reg(REG_STEP, (p == 2) ? 64'h8000_0000 : (p == 3) ? 64'h7FFF_FFFF :
                (p == 4) ? 64'd0 : 64'($urandom));
      write_reg(REG_OFFSET, 64'($urandom));
      write_reg(REG_LEVEL, (p == 5) ? 64'd0 : (p == 6) ? 64'd65536 :
                64'($urandom_range(131071)));
      write_reg(REG_CHANNELS, 64'($urandom_range(15)));
      random_phase(60);
    end
    calm = 0;

    if (errors == 0 && shifted_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== iir_hilbert_frequency_shifter.f =====
sv/fhs_pkg.sv
sv/fhs_ram.sv
sv/fhs_front.sv
sv/fhs_fifo.sv
sv/fhs_back.sv
sv/iir_hilbert_frequency_shifter.sv
bench/tb_top.sv
